### hw/rtl/excitation_trim_and_pressure_scale_macros.svh
// Assertion macros shared by the trim and pressure scaler RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef EXCITATION_TRIM_AND_PRESSURE_SCALE_MACROS_SVH
`define EXCITATION_TRIM_AND_PRESSURE_SCALE_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge, suspended while reset is high.
`define ETPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge, reset included.
`define ETPS_ASSERT_NRST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ETPS_ASSERT(lbl, clk, rst, prop, msg)
`define ETPS_ASSERT_NRST(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/etps_pkg.sv
// Shared types and constants for the excitation trim and pressure scaler.
// No dependencies; imported by the front end, the back end and the top level.
`timescale 1ns / 1ps
package etps_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 22;
  localparam logic [CFG_ADDR_W-1:0] REG_SHUNT_TARGET  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DAC_LOW       = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DAC_HIGH      = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET   = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOPE         = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KPA_OFFSET    = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_KPA_MAX       = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_PERCENT_GAIN  = 4'd7;

  // Register reset values
  localparam logic [11:0] RST_SHUNT_TARGET = 12'd200;
  localparam logic [7:0]  RST_DAC_LOW      = 8'd150;
  localparam logic [7:0]  RST_DAC_HIGH     = 8'd190;
  localparam logic [11:0] RST_ZERO_OFFSET  = 12'd85;
  localparam logic [15:0] RST_SLOPE        = 16'd1416;
  localparam logic [21:0] RST_KPA_OFFSET   = 22'd196608;
  localparam logic [5:0]  RST_KPA_MAX      = 6'd37;
  localparam logic [19:0] RST_PERCENT_GAIN = 20'd176947;

  localparam logic [7:0] DAC_RESET_LEVEL = 8'd150;
  localparam logic [7:0] FRAME_START     = 8'h5F;
  localparam logic [7:0] FRAME_END       = 8'hA0;
  localparam logic [7:0] ERROR_PERCENT   = 8'd100;

  // Input command codes and result kinds
  localparam logic CMD_SHUNT    = 1'b0;
  localparam logic CMD_PRESSURE = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  typedef enum logic {
    OP_TRIM,
    OP_FRAME
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_CLAMP,
    BS_GAIN,
    BS_START,
    BS_PCT,
    BS_END
  } back_state_t;

  typedef struct packed {
    logic [11:0] shunt_target_mv;
    logic [7:0]  dac_low_limit;
    logic [7:0]  dac_high_limit;
    logic [11:0] sensor_zero_offset;
    logic [15:0] slope_q16;
    logic [21:0] kpa_offset_q16;
    logic [5:0]  kpa_max;
    logic [19:0] percent_gain_q16;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] dac_level;
    logic       settled;
    logic       hw_error;
    logic [7:0] frame_byte;
    logic       last;
  } res_t;

endpackage

### hw/rtl/etps_fifo.sv
// Short transaction queue between the front and back ends.
// Depends on the assertion macros header.
`timescale 1ns / 1ps
`include "excitation_trim_and_pressure_scale_macros.svh"
module etps_fifo #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `ETPS_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue fill count beyond depth")
  `ETPS_ASSERT(a_ptr_gap, clk, rst, (count == '0) |-> (wptr == rptr), "empty queue with pointer gap")
  `ETPS_ASSERT(a_no_lost_write, clk, rst, (do_wr && !do_rd) |=> (count != '0), "write lost")

endmodule

### hw/rtl/etps_front.sv
// Front end: takes input transactions, classifies them and feeds the queue.
// Depends on etps_pkg.
`timescale 1ns / 1ps
module etps_front #(
  parameter int unsigned SAMPLE_BITS = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   q_wr,
  output logic [SAMPLE_BITS:0]   q_wdata,
  input  logic                   q_full
);
  import etps_pkg::*;

  logic                   fv;
  op_t                    op;
  logic [SAMPLE_BITS-1:0] smp;

  // Staged item holds while the queue is full
  assign full    = fv && q_full;
  assign q_wr    = fv;
  assign q_wdata = {op, smp};

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!full) begin
      fv <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && push) begin
      op  <= (cmd == CMD_PRESSURE) ? OP_FRAME : OP_TRIM;
      smp <= sample;
    end
  end

endmodule

### hw/rtl/etps_back.sv
// Back end: runs the trim step or the pressure scaling, emits results.
// Depends on etps_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "excitation_trim_and_pressure_scale_macros.svh"
module etps_back #(
  parameter int unsigned SAMPLE_BITS = 13
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [SAMPLE_BITS:0]   q_rdata,
  output logic                   q_rd,
  input  etps_pkg::cfg_t         cfg,
  input  logic                   take,
  output logic                   out_valid,
  output etps_pkg::res_t         res
);
  import etps_pkg::*;

  localparam int unsigned ADJ_W  = ((SAMPLE_BITS > 13) ? SAMPLE_BITS : 13) + 1;
  localparam int unsigned SUM_W  = ADJ_W + 1;
  localparam int unsigned PROD_W = ADJ_W + 17;
  localparam int unsigned KQ_W   = PROD_W + 1;

  back_state_t state;
  back_state_t state_next;

  logic [7:0] dac_level;
  logic [7:0] dac_next;
  logic       error_latched;
  logic       err_next;
  logic       load;
  res_t       res_next;
  logic       slot_free;

  op_t                    q_op;
  logic [SAMPLE_BITS-1:0] q_smp;

  // Trim datapath
  logic signed [ADJ_W-1:0] diff;
  logic signed [ADJ_W-1:0] diff_adj;
  logic signed [ADJ_W-1:0] step;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lo_ext;
  logic signed [SUM_W-1:0] hi_ext;
  logic                    settle;
  logic                    clamp;
  logic [7:0]              trim_level;

  // Pressure datapath
  logic [SAMPLE_BITS-1:0]   smp;
  logic signed [ADJ_W-1:0]  adj;
  logic signed [PROD_W-1:0] prod1;
  logic signed [KQ_W-1:0]   kq;
  logic signed [KQ_W-1:0]   top;
  logic [21:0]              kqc;
  logic [41:0]              prod2;
  logic [9:0]               pct_raw;
  logic [7:0]               pct;

  assign q_op      = op_t'(q_rdata[SAMPLE_BITS]);
  assign q_smp     = q_rdata[SAMPLE_BITS-1:0];
  assign slot_free = !out_valid || take;

  assign diff = $signed({{(ADJ_W-12){1'b0}}, cfg.shunt_target_mv})
              - $signed({{(ADJ_W-SAMPLE_BITS){q_smp[SAMPLE_BITS-1]}}, q_smp});
  assign settle = (diff == '0) || (diff == ADJ_W'(1)) || (diff == {ADJ_W{1'b1}});
  // Halve with truncation toward zero
  assign diff_adj = diff + $signed({{(ADJ_W-1){1'b0}}, diff[ADJ_W-1]});
  assign step     = diff_adj >>> 1;
  assign sum      = $signed({{(SUM_W-8){1'b0}}, dac_level}) + $signed({step[ADJ_W-1], step});
  assign lo_ext   = $signed({{(SUM_W-8){1'b0}}, cfg.dac_low_limit});
  assign hi_ext   = $signed({{(SUM_W-8){1'b0}}, cfg.dac_high_limit});

  always_comb begin
    clamp      = 1'b0;
    trim_level = dac_level;
    if (!settle) begin
      if (sum < lo_ext) begin
        trim_level = cfg.dac_low_limit;
        clamp      = 1'b1;
      end else if (sum > hi_ext) begin
        trim_level = cfg.dac_high_limit;
        clamp      = 1'b1;
      end else begin
        trim_level = sum[7:0];
      end
    end
  end

  assign adj = $signed({{(ADJ_W-SAMPLE_BITS){smp[SAMPLE_BITS-1]}}, smp})
             - $signed({{(ADJ_W-12){1'b0}}, cfg.sensor_zero_offset});
  assign kq  = $signed({prod1[PROD_W-1], prod1})
             + $signed({{(KQ_W-22){1'b0}}, cfg.kpa_offset_q16});
  assign top = $signed({{(KQ_W-22){1'b0}}, cfg.kpa_max, 16'h0000});
  assign pct_raw = prod2[41:32];
  assign pct = error_latched ? ERROR_PERCENT
             : ((pct_raw[9:8] != 2'b00) ? 8'hFF : pct_raw[7:0]);

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    load       = 1'b0;
    dac_next   = dac_level;
    err_next   = error_latched;
    res_next   = '{kind: KIND_FRAME, dac_level: dac_level, settled: 1'b0,
                   hw_error: error_latched, frame_byte: 8'h00, last: 1'b0};
    case (state)
      BS_IDLE: begin
        if (q_valid) begin
          if (q_op == OP_TRIM) begin
            if (slot_free) begin
              q_rd     = 1'b1;
              load     = 1'b1;
              dac_next = trim_level;
              err_next = clamp;
              res_next = '{kind: KIND_STATUS, dac_level: trim_level, settled: settle,
                           hw_error: clamp, frame_byte: 8'h00, last: 1'b1};
            end
          end else begin
            q_rd       = 1'b1;
            state_next = BS_MUL;
          end
        end
      end
      BS_MUL:   state_next = BS_CLAMP;
      BS_CLAMP: state_next = BS_GAIN;
      BS_GAIN:  state_next = BS_START;
      BS_START: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.frame_byte = FRAME_START;
          state_next          = BS_PCT;
        end
      end
      BS_PCT: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.frame_byte = pct;
          state_next          = BS_END;
        end
      end
      BS_END: begin
        if (slot_free) begin
          load                = 1'b1;
          res_next.frame_byte = FRAME_END;
          res_next.last       = 1'b1;
          state_next          = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BS_IDLE;
      dac_level     <= DAC_RESET_LEVEL;
      error_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      dac_level     <= dac_next;
      error_latched <= err_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
    if (q_rd && (q_op == OP_FRAME)) begin
      smp <= q_smp;
    end
    if (state == BS_MUL) begin
      prod1 <= adj * $signed({1'b0, cfg.slope_q16});
    end
    if (state == BS_CLAMP) begin
      if (kq[KQ_W-1]) begin
        kqc <= '0;
      end else if (kq > top) begin
        kqc <= top[21:0];
      end else begin
        kqc <= kq[21:0];
      end
    end
    if (state == BS_GAIN) begin
      prod2 <= {20'h00000, kqc} * {22'h000000, cfg.percent_gain_q16};
    end
  end

  `ETPS_ASSERT(a_state_hold, clk, rst, (state != BS_IDLE) |=> ($stable(dac_level) && $stable(error_latched)), "trim state moved during a frame")
  `ETPS_ASSERT(a_status_last, clk, rst, (out_valid && (res.kind == KIND_STATUS)) |-> (res.last && (res.frame_byte == 8'h00)), "status result malformed")
  `ETPS_ASSERT(a_pop_idle, clk, rst, q_rd |-> (state == BS_IDLE), "queue read outside idle")

endmodule

### hw/rtl/excitation_trim_and_pressure_scale.sv
// Excitation trim and pressure scaler, top level.
// Data path: a shunt result passes the front staging register, the queue and the output
// register; a pressure frame adds the multiply chain, then one byte per cycle while popped.
// Throughput: one shunt transaction per cycle while results are popped; a pressure
// transaction holds the back end for the queue read, three chain stages and three byte slots.
// Synchronous reset clears queue, output slot, DAC level (to 150), error flag and state.
`timescale 1ns / 1ps
module excitation_trim_and_pressure_scale #(
  parameter int unsigned SAMPLE_BITS = 13
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            cmd,
  input  logic [SAMPLE_BITS-1:0]          sample,
  // Result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic                            kind,
  output logic [7:0]                      dac_level_out,
  output logic                            settled,
  output logic                            hw_error,
  output logic [7:0]                      frame_byte,
  output logic                            last,
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [etps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [etps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import etps_pkg::*;

  localparam int unsigned ITEM_W = SAMPLE_BITS + 1;

  cfg_t              cfg;
  logic              q_wr;
  logic [ITEM_W-1:0] q_wdata;
  logic              q_full;
  logic              q_rd;
  logic [ITEM_W-1:0] q_rdata;
  logic              q_empty;
  logic              out_valid;
  logic              take;
  res_t              res;

  // Configuration registers; writes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shunt_target_mv    <= RST_SHUNT_TARGET;
      cfg.dac_low_limit      <= RST_DAC_LOW;
      cfg.dac_high_limit     <= RST_DAC_HIGH;
      cfg.sensor_zero_offset <= RST_ZERO_OFFSET;
      cfg.slope_q16          <= RST_SLOPE;
      cfg.kpa_offset_q16     <= RST_KPA_OFFSET;
      cfg.kpa_max            <= RST_KPA_MAX;
      cfg.percent_gain_q16   <= RST_PERCENT_GAIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SHUNT_TARGET: cfg.shunt_target_mv    <= cfg_wdata[11:0];
        REG_DAC_LOW:      cfg.dac_low_limit      <= cfg_wdata[7:0];
        REG_DAC_HIGH:     cfg.dac_high_limit     <= cfg_wdata[7:0];
        REG_ZERO_OFFSET:  cfg.sensor_zero_offset <= cfg_wdata[11:0];
        REG_SLOPE:        cfg.slope_q16          <= cfg_wdata[15:0];
        REG_KPA_OFFSET:   cfg.kpa_offset_q16     <= cfg_wdata[21:0];
        REG_KPA_MAX:      cfg.kpa_max            <= cfg_wdata[5:0];
        REG_PERCENT_GAIN: cfg.percent_gain_q16   <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Front end: one staging register, tags each transaction as trim or frame work
  etps_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .sample  (sample),
    .q_wr    (q_wr),
    .q_wdata (q_wdata),
    .q_full  (q_full)
  );

  // Two-entry queue lets the front keep taking samples while frames drain
  etps_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back end: trim loop state, pressure multiply chain and the output slot
  etps_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .cfg       (cfg),
    .take      (take),
    .out_valid (out_valid),
    .res       (res)
  );

  assign empty         = !out_valid;
  assign take          = pop && out_valid;
  assign kind          = res.kind;
  assign dac_level_out = res.dac_level;
  assign settled       = res.settled;
  assign hw_error      = res.hw_error;
  assign frame_byte    = res.frame_byte;
  assign last          = res.last;

endmodule
